FILE: src/kdtt_pkg.sv
// ----------------------------------------------------------------------------
// kdtt_pkg
// Types, sizes and command codes shared by the keyed deadline timer table.
// ----------------------------------------------------------------------------
package kdtt_pkg;

  localparam int unsigned POOL_ENTRIES = 256;
  localparam int unsigned OWNER_COUNT  = 1024;
  localparam int unsigned KEY_BITS     = 12;

  localparam int unsigned OWNER_W = 10;
  localparam int unsigned KEY_W   = 12;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned IDX_W   = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(POOL_ENTRIES + 1);

  typedef enum logic [3:0] {
    CMD_SET         = 4'd0,
    CMD_START       = 4'd1,
    CMD_GET         = 4'd2,
    CMD_DONE        = 4'd3,
    CMD_STRICT_DONE = 4'd4,
    CMD_EXISTS      = 4'd5,
    CMD_REMOVE      = 4'd6,
    CMD_CLEAR_OWNER = 4'd7,
    CMD_CLEAR_ALL   = 4'd8
  } cmd_e;

  typedef struct packed {
    logic [3:0]                cmd;
    logic [OWNER_W-1:0]        owner;
    logic [KEY_W-1:0]          timer_key;
    logic signed [TIME_W-1:0]  duration;
    logic signed [TIME_W-1:0]  now;
    logic                      release_when_done;
  } req_t;

  typedef struct packed {
    logic                      found;
    logic                      answer;
    logic signed [TIME_W-1:0]  deadline;
    logic                      pool_full;
  } rsp_t;

  typedef struct packed {
    logic [OWNER_W-1:0]        owner;
    logic [KEY_BITS-1:0]       key;
    logic signed [TIME_W-1:0]  deadline;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_en;
    logic commit;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } sts_t;

  // commands that walk the pool before committing
  function automatic logic cmd_needs_scan(input logic [3:0] c);
    case (c)
      CMD_SET, CMD_START, CMD_GET, CMD_DONE, CMD_STRICT_DONE,
      CMD_EXISTS, CMD_REMOVE, CMD_CLEAR_OWNER: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

FILE: src/kdtt_dpath.sv
// ----------------------------------------------------------------------------
// kdtt_dpath
// Entry store, valid flags, pool scan (match and first free) and commit logic.
// ----------------------------------------------------------------------------
module kdtt_dpath import kdtt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctl_t  ctl_i,
  output sts_t  sts_o,
  input  req_t  req_i,
  output rsp_t  rsp_o
);

  entry_t mem [POOL_ENTRIES];

  logic [POOL_ENTRIES-1:0] valid_q, valid_d;

  req_t                     req_q;
  logic [CNT_W-1:0]         addr_q;
  logic                     cmp_vld_q;
  logic [IDX_W-1:0]         cmp_idx_q;
  entry_t                   rd_q;
  logic                     hit_q;
  logic [IDX_W-1:0]         hit_idx_q;
  logic signed [TIME_W-1:0] hit_dl_q;
  logic                     free_q;
  logic [IDX_W-1:0]         free_idx_q;
  rsp_t                     rsp_q, rsp_d;

  logic                     cmp_valid, owner_eq, key_eq, is_clr_owner, owner_ok;
  logic                     step, match, last, addr_live;
  logic                     expired, set_full, wr_en, rel_en, clr_all;
  logic [IDX_W-1:0]         wr_idx;
  logic signed [TIME_W-1:0] new_dl;
  entry_t                   wr_entry;

  // compare stage: one entry a cycle, in the cycle after that entry's read
  assign cmp_valid    = valid_q[cmp_idx_q];
  assign owner_eq     = (rd_q.owner == req_q.owner);
  assign key_eq       = (rd_q.key == req_q.timer_key[KEY_BITS-1:0]);
  assign is_clr_owner = (req_q.cmd == CMD_CLEAR_OWNER);
  assign owner_ok     = (32'(req_q.owner) < OWNER_COUNT);
  assign step         = ctl_i.scan_en && cmp_vld_q;
  assign match        = step && cmp_valid && owner_eq && (key_eq || is_clr_owner);
  assign last         = (cmp_idx_q == IDX_W'(POOL_ENTRIES - 1));
  assign addr_live    = (addr_q < CNT_W'(POOL_ENTRIES));

  assign sts_o.scan_done = step && (last || (match && !is_clr_owner));

  // commit
  assign expired  = (hit_dl_q < req_q.now);
  assign new_dl   = req_q.now + req_q.duration;
  assign set_full = !hit_q && !free_q;
  assign wr_idx   = hit_q ? hit_idx_q : free_idx_q;

  always_comb begin
    rsp_d   = '0;
    wr_en   = 1'b0;
    rel_en  = 1'b0;
    clr_all = 1'b0;
    case (req_q.cmd)
      CMD_SET: begin
        rsp_d.found     = hit_q;
        rsp_d.pool_full = set_full;
        wr_en           = !set_full;
      end
      CMD_START: begin
        rsp_d.found = hit_q;
        if (!hit_q || expired) begin
          rsp_d.answer    = 1'b1;
          rsp_d.pool_full = set_full;
          wr_en           = !set_full;
        end
      end
      CMD_GET: begin
        rsp_d.found    = hit_q;
        rsp_d.deadline = hit_q ? hit_dl_q : '1;
      end
      CMD_DONE: begin
        rsp_d.found  = hit_q;
        rsp_d.answer = !hit_q || expired;
      end
      CMD_STRICT_DONE: begin
        rsp_d.found  = hit_q;
        rsp_d.answer = hit_q && expired;
        rel_en       = hit_q && expired && req_q.release_when_done;
      end
      CMD_EXISTS: begin
        rsp_d.found  = hit_q;
        rsp_d.answer = hit_q;
      end
      CMD_REMOVE: begin
        rsp_d.found = hit_q;
        rel_en      = hit_q;
      end
      CMD_CLEAR_ALL: begin
        clr_all = 1'b1;
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  assign wr_entry.owner    = req_q.owner;
  assign wr_entry.key      = req_q.timer_key[KEY_BITS-1:0];
  assign wr_entry.deadline = new_dl;

  always_comb begin
    valid_d = valid_q;
    if (match && is_clr_owner && owner_ok) begin
      valid_d[cmp_idx_q] = 1'b0;
    end
    if (ctl_i.commit) begin
      if (clr_all) begin
        valid_d = '0;
      end
      if (rel_en) begin
        valid_d[hit_idx_q] = 1'b0;
      end
      if (wr_en) begin
        valid_d[wr_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      addr_q    <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctl_i.load) begin
        addr_q    <= '0;
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
        free_q    <= 1'b0;
      end else if (ctl_i.scan_en) begin
        if (addr_live) begin
          addr_q <= addr_q + CNT_W'(1);
        end
        cmp_vld_q <= addr_live;
        if (match && !is_clr_owner) begin
          hit_q <= 1'b1;
        end
        if (step && !cmp_valid) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
    end
    if (ctl_i.scan_en) begin
      rd_q      <= mem[addr_q[IDX_W-1:0]];
      cmp_idx_q <= addr_q[IDX_W-1:0];
      if (match && !is_clr_owner) begin
        hit_idx_q <= cmp_idx_q;
        hit_dl_q  <= rd_q.deadline;
      end
      // lowest free index only
      if (step && !cmp_valid && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
    if (ctl_i.commit) begin
      rsp_q <= rsp_d;
      if (wr_en) begin
        mem[wr_idx] <= wr_entry;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

FILE: src/kdtt_ctrl.sv
// ----------------------------------------------------------------------------
// kdtt_ctrl
// Sequencer: accept an item, walk the pool where the command needs it, commit and hold the result.
// ----------------------------------------------------------------------------
module kdtt_ctrl import kdtt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] in_cmd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ctl_t       ctl_o,
  input  sts_t       sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept, out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // result register can take a new item this cycle
  assign out_free   = !out_valid_q || out_ready_i;

  assign ctl_o.load    = accept;
  assign ctl_o.scan_en = (state_q == ST_SCAN);
  assign ctl_o.commit  = (state_q == ST_COMMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // a held result leaves on its handshake, a committed one takes its place
      out_valid_q <= ctl_o.commit || (out_valid_q && !out_ready_i);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= cmd_needs_scan(in_cmd_i) ? ST_SCAN : ST_COMMIT;
          end
        end
        ST_SCAN: begin
          if (sts_i.scan_done) begin
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/keyed_deadline_timer_table_core.sv
// ----------------------------------------------------------------------------
// keyed_deadline_timer_table_core
// Shared pool of deadline timers keyed by owner and name handle.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i / in_ready_o / in_req_i): one request item,
//     command plus owner, key, duration, current time and release flag.
//   out channel (out_valid_o / out_ready_i / out_rsp_o): one result item per
//     request, in request order.
//   Lookups walk the entry store one entry a cycle through its single read
//   port. An item whose timer sits at entry i ends its walk at entry i;
//   a miss, or clear owner, walks all POOL_ENTRIES entries. Clear all and
//   unknown commands skip the walk and go straight to commit. One item is
//   in work at a time; the next is taken once the previous result is
//   registered. Reset clears all valid flags at once, so the pool is empty
//   with no clearing pass. A held result stays on out_rsp_o while the
//   receiver stalls; the next item may already be accepted and scanned,
//   and waits at commit until the result register is free.
// ----------------------------------------------------------------------------
module keyed_deadline_timer_table_core import kdtt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  ctl_t ctl;
  sts_t sts;

  kdtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_cmd_i    (in_req_i.cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  kdtt_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .sts_o  (sts),
    .req_i  (in_req_i),
    .rsp_o  (out_rsp_o)
  );

endmodule

FILE: src/kdtt_checker.sv
// ----------------------------------------------------------------------------
// kdtt_checker
// Port-level checks on the timer table, bound to the top level.
// ----------------------------------------------------------------------------
module kdtt_checker import kdtt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_rsp_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while busy");

  // no result appears in the cycle right after an item is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o || $past(out_valid_o))
    else $error("result too early");

  // a full pool only matters when the timer was absent
  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.pool_full |-> !out_rsp_o.found)
    else $error("pool full reported on a present timer");

  // only get returns a deadline
  a_deadline_only_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.deadline != '0) |-> !out_rsp_o.answer && !out_rsp_o.pool_full)
    else $error("deadline on a non-get result");

endmodule

bind keyed_deadline_timer_table_core kdtt_checker u_kdtt_checker (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for keyed_deadline_timer_table_core. Items go in through
// a table of directed requests, then random phases: a mixed phase on a few
// owners and keys, a fill to a full pool, traffic on the full pool and a
// phase with wide random fields. Each accepted request is run through a
// local timer pool model and every result item is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
  import kdtt_pkg::*;

  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } probe_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_rsp_o;

  // local copy of the timer pool
  bit                       pool_valid    [POOL_ENTRIES];
  logic [OWNER_W-1:0]       pool_owner    [POOL_ENTRIES];
  logic [KEY_BITS-1:0]      pool_key      [POOL_ENTRIES];
  logic signed [TIME_W-1:0] pool_deadline [POOL_ENTRIES];

  // pairs written while filling the pool
  logic [OWNER_W-1:0] fill_owner [POOL_ENTRIES];
  logic [KEY_W-1:0]   fill_key   [POOL_ENTRIES];

  rsp_t        pending_rsp[$];
  probe_row_t  probe_rows[$];
  int unsigned mismatch_count = 0;
  int unsigned in_quiet = 0;
  int unsigned out_quiet = 0;
  logic signed [TIME_W-1:0] clock_ms = 0;

  keyed_deadline_timer_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic rsp_t rsp_of(input int unsigned f, input int unsigned a,
                                  input logic [31:0] dl, input int unsigned full);
    rsp_t o;
    o.found     = 1'(f);
    o.answer    = 1'(a);
    o.deadline  = dl;
    o.pool_full = 1'(full);
    return o;
  endfunction

  // Writes the deadline into the hit entry or the lowest free one; 0 when full.
  function automatic bit store_deadline(input int hit, input req_t r,
                                        input logic signed [TIME_W-1:0] nd);
    int slot;
    int i;
    slot = hit;
    if (slot < 0) begin
      for (i = 0; i < POOL_ENTRIES; i++)
        if (slot < 0 && !pool_valid[i]) slot = i;
    end
    if (slot < 0) return 1'b0;
    pool_valid[slot]    = 1'b1;
    pool_owner[slot]    = r.owner;
    pool_key[slot]      = r.timer_key[KEY_BITS-1:0];
    pool_deadline[slot] = nd;
    return 1'b1;
  endfunction

  function automatic rsp_t predict_timer_rsp(input req_t r);
    rsp_t o;
    int hit;
    int i;
    logic signed [TIME_W-1:0] nd;
    bit live;
    bit lapsed;
    o = '0;
    hit = -1;
    lapsed = 1'b0;
    nd = r.now + r.duration;
    for (i = 0; i < POOL_ENTRIES; i++)
      if (hit < 0 && pool_valid[i] && pool_owner[i] == r.owner &&
          pool_key[i] == r.timer_key[KEY_BITS-1:0])
        hit = i;
    live = (hit >= 0);
    if (live) lapsed = (pool_deadline[hit] < r.now);
    case (r.cmd)
      CMD_SET: begin
        o.found     = live;
        o.pool_full = !store_deadline(hit, r, nd);
      end
      CMD_START: begin
        o.found = live;
        if (!live || lapsed) begin
          o.answer    = 1'b1;
          o.pool_full = !store_deadline(hit, r, nd);
        end
      end
      CMD_GET: begin
        o.found    = live;
        o.deadline = live ? pool_deadline[hit] : '1;
      end
      CMD_DONE: begin
        o.found  = live;
        o.answer = !live || lapsed;
      end
      CMD_STRICT_DONE: begin
        o.found  = live;
        o.answer = lapsed;
        if (lapsed && r.release_when_done) pool_valid[hit] = 1'b0;
      end
      CMD_EXISTS: begin
        o.found  = live;
        o.answer = live;
      end
      CMD_REMOVE: begin
        o.found = live;
        if (live) pool_valid[hit] = 1'b0;
      end
      CMD_CLEAR_OWNER: begin
        if (r.owner < OWNER_COUNT)
          for (i = 0; i < POOL_ENTRIES; i++)
            if (pool_valid[i] && pool_owner[i] == r.owner) pool_valid[i] = 1'b0;
      end
      CMD_CLEAR_ALL: begin
        for (i = 0; i < POOL_ENTRIES; i++) pool_valid[i] = 1'b0;
      end
      default: ;
    endcase
    return o;
  endfunction

  // mostly short gaps, a few long ones, now and then a run with none
  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned w;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    w = $urandom_range(0, 99);
    if (w < 2) quiet = $urandom_range(20, 60);
    if (w < 40) return 0;
    if (w < 85) return $urandom_range(1, 3);
    if (w < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [3:0] pick_cmd(input bit allow_clear_all);
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 20) return CMD_SET;
    if (w < 35) return CMD_START;
    if (w < 47) return CMD_GET;
    if (w < 57) return CMD_DONE;
    if (w < 70) return CMD_STRICT_DONE;
    if (w < 78) return CMD_EXISTS;
    if (w < 92) return CMD_REMOVE;
    if (w < 96) return CMD_CLEAR_OWNER;
    if (w < 97) return allow_clear_all ? CMD_CLEAR_ALL : CMD_GET;
    return 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
  endfunction

  function automatic req_t random_req(input int unsigned wide_pct, input bit from_fill,
                                      input bit allow_clear_all);
    req_t r;
    int unsigned j;
    int unsigned w;
    bit wide;
    wide = ($urandom_range(0, 99) < wide_pct);
    clock_ms = clock_ms + $urandom_range(0, 20);
    if ($urandom_range(0, 99) == 0) clock_ms = $urandom;
    r.cmd = wide ? 4'($urandom_range(0, 15)) : pick_cmd(allow_clear_all);
    r.release_when_done = 1'($urandom_range(0, 1));
    if (wide) begin
      r.owner     = OWNER_W'($urandom);
      r.timer_key = KEY_W'($urandom);
      r.duration  = $urandom;
      r.now       = $urandom;
    end else begin
      r.owner = ($urandom_range(0, 3) == 3) ? OWNER_W'(OWNER_COUNT - 1)
                                            : OWNER_W'($urandom_range(0, 2));
      r.timer_key = ($urandom_range(0, 9) == 0) ? '1 : KEY_W'($urandom_range(0, 9));
      w = $urandom_range(0, 9);
      if (w < 6) r.duration = int'($urandom_range(0, 100)) - 20;
      else if (w < 9) r.duration = $urandom_range(500, 50000);
      else r.duration = $urandom;
      if ($urandom_range(0, 19) == 0) r.now = $urandom;
      else r.now = clock_ms + int'($urandom_range(0, 60)) - 30;
      if (from_fill && $urandom_range(0, 9) < 6) begin
        j = $urandom_range(0, POOL_ENTRIES - 1);
        r.owner     = fill_owner[j];
        r.timer_key = fill_key[j];
      end
    end
    return r;
  endfunction

  function automatic void probe(input logic [3:0] c, input int unsigned ow,
                                input int unsigned kt, input logic [31:0] dur,
                                input logic [31:0] nw, input int unsigned rel,
                                input int unsigned typed, input rsp_t want);
    probe_row_t row;
    row.req.cmd               = c;
    row.req.owner             = OWNER_W'(ow);
    row.req.timer_key         = KEY_W'(kt);
    row.req.duration          = dur;
    row.req.now               = nw;
    row.req.release_when_done = 1'(rel);
    row.typed                 = 1'(typed);
    row.want                  = want;
    probe_rows.push_back(row);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_req(input req_t r, input bit typed, input rsp_t want);
    int unsigned gap;
    rsp_t p;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    p = predict_timer_rsp(r);
    pending_rsp.push_back(typed ? want : p);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    req_t r;
    rsp_t idle_rsp;
    int i;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    idle_rsp    = rsp_of(0, 0, 0, 0);

    probe(CMD_GET,         0,    0,    0, 0, 0, 1, rsp_of(0, 0, '1, 0));
    probe(CMD_DONE,        0,    0,    0, 0, 0, 1, rsp_of(0, 1, 0, 0));
    probe(CMD_STRICT_DONE, 0,    0,    0, 0, 1, 1, idle_rsp);
    probe(CMD_EXISTS,      1023, 4095, 0, 0, 0, 1, idle_rsp);
    probe(CMD_REMOVE,      1023, 4095, 0, 0, 0, 1, idle_rsp);
    probe(CMD_UNUSED_HI,   1023, 4095, '1, '1, 1, 1, idle_rsp);
    probe(CMD_UNUSED_LO,   0,    0,    0, 0, 0, 1, idle_rsp);
    // max duration wraps the deadline round to the most negative time
    probe(CMD_SET,  1023, 4095, 32'h7FFF_FFFF, 1, 0, 1, idle_rsp);
    probe(CMD_GET,  1023, 4095, 0, 0, 0, 1, rsp_of(1, 0, 32'h8000_0000, 0));
    probe(CMD_DONE, 1023, 4095, 0, 0, 0, 1, rsp_of(1, 1, 0, 0));
    probe(CMD_SET,   0, 0, 100, 1000, 0, 0, idle_rsp);
    probe(CMD_START, 0, 0, 5,   1050, 0, 0, idle_rsp);
    probe(CMD_START, 0, 0, 5,   1101, 0, 0, idle_rsp);
    probe(CMD_EXISTS, 0, 0, 0, 0, 0, 0, idle_rsp);
    // deadline equal to now is not yet expired
    probe(CMD_STRICT_DONE, 0, 0, 0, 1106, 1, 0, idle_rsp);
    probe(CMD_STRICT_DONE, 0, 0, 0, 1107, 0, 0, idle_rsp);
    probe(CMD_STRICT_DONE, 0, 0, 0, 1107, 1, 0, idle_rsp);
    probe(CMD_EXISTS, 0, 0, 0, 0, 0, 0, idle_rsp);
    probe(CMD_SET, 5, 7, '1, 32'h8000_0000, 0, 0, idle_rsp);
    probe(CMD_GET, 5, 7, 0, 0, 0, 0, idle_rsp);
    probe(CMD_REMOVE, 1023, 4095, 0, 0, 0, 0, idle_rsp);
    // absent timer: start claims the lowest free entry
    probe(CMD_START, 5, 8, 10, 0, 0, 0, idle_rsp);
    probe(CMD_CLEAR_OWNER, 5, 0, 0, 0, 0, 1, idle_rsp);
    probe(CMD_EXISTS, 5, 7, 0, 0, 0, 0, idle_rsp);
    probe(CMD_CLEAR_ALL, 0, 0, 0, 0, 0, 1, idle_rsp);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (probe_rows[k]) issue_req(probe_rows[k].req, probe_rows[k].typed, probe_rows[k].want);

    // mixed traffic on a handful of owners and keys
    repeat (450) issue_req(random_req(0, 1'b0, 1'b1), 1'b0, idle_rsp);

    // empty the pool, then fill every entry with a distinct pair
    r = '0;
    r.cmd = CMD_CLEAR_ALL;
    issue_req(r, 1'b0, idle_rsp);
    for (i = 0; i < POOL_ENTRIES; i++) begin
      r = random_req(0, 1'b0, 1'b1);
      r.cmd       = CMD_SET;
      r.owner     = OWNER_W'($urandom);
      r.timer_key = {4'($urandom), 8'(i)};
      r.now       = clock_ms;
      r.duration  = $urandom_range(0, 1) ? int'($urandom_range(500, 5000))
                                         : int'($urandom_range(0, 40));
      fill_owner[i] = r.owner;
      fill_key[i]   = r.timer_key;
      issue_req(r, 1'b0, idle_rsp);
    end

    // full pool: hits on filled pairs, misses that find no room, releases
    repeat (250) issue_req(random_req(0, 1'b1, 1'b0), 1'b0, idle_rsp);

    // wide random fields mixed with ordinary traffic
    repeat (170) issue_req(random_req(40, 1'b0, 1'b1), 1'b0, idle_rsp);

    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** keyed_deadline_timer_table_core: PASSED **");
    end else begin
      $display("** keyed_deadline_timer_table_core: FAILED **");
    end
    $finish;
  end

  initial begin : result_side
    int unsigned stall;
    int unsigned open_len;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall    = pick_gap(out_quiet);
      open_len = $urandom_range(1, 12);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (open_len) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        flag_mismatch("item with none pending", out_rsp_o.deadline, '0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp_o.found !== want.found)
          flag_mismatch("found", 32'(out_rsp_o.found), 32'(want.found));
        if (out_rsp_o.answer !== want.answer)
          flag_mismatch("answer", 32'(out_rsp_o.answer), 32'(want.answer));
        if (out_rsp_o.deadline !== want.deadline)
          flag_mismatch("deadline", out_rsp_o.deadline, want.deadline);
        if (out_rsp_o.pool_full !== want.pool_full)
          flag_mismatch("pool_full", 32'(out_rsp_o.pool_full), 32'(want.pool_full));
      end
    end
  end

  initial begin : watchdog
    #40_000_000;
    $display("** keyed_deadline_timer_table_core: FAILED **");
    $finish;
  end

endmodule
